### design/wrld_pkg.sv
// Shared types and constants of the work rate limiter.
// Holds the command/status structs between controller and datapath.
// No dependencies.
package wrld_pkg;

    localparam int unsigned UNITS_PER_SECOND = 1000000000;
    localparam int unsigned TICKS_PER_SECOND = 100;
    localparam int unsigned TICK_LEN_RAW = UNITS_PER_SECOND / TICKS_PER_SECOND;
    localparam int unsigned TICK_LEN = (TICK_LEN_RAW == 0) ? 1 : TICK_LEN_RAW;

    localparam int TIME_W  = 64;
    localparam int WORK_W  = 32;
    localparam int RATE_W  = 32;
    localparam int DELAY_W = 10;
    localparam int UNITS_W = $clog2(UNITS_PER_SECOND + 1);
    localparam int PROD_W  = WORK_W + UNITS_W;
    localparam int CNT_W   = $clog2(TIME_W + 1);

    // Tick count by reciprocal multiply: exact floor for any UNITS_W-bit difference
    localparam int TICK_SHIFT = UNITS_W + $clog2(TICK_LEN);
    localparam int TREC_W     = 32;
    localparam int TPROD_W    = UNITS_W + TREC_W;
    localparam logic [63:0] TICK_RECIP_RAW =
        ((64'd1 << TICK_SHIFT) + 64'(TICK_LEN) - 64'd1) / 64'(TICK_LEN);

    localparam logic [TIME_W-1:0]  UNITS_T    = TIME_W'(UNITS_PER_SECOND);
    localparam logic [TIME_W-1:0]  UNITS2_T   = TIME_W'(2 * 64'(UNITS_PER_SECOND));
    localparam logic [TREC_W-1:0]  TICK_RECIP = TREC_W'(TICK_RECIP_RAW);
    localparam logic [TIME_W-1:0]  DELAY_MAX  = TIME_W'((1 << DELAY_W) - 1);
    localparam logic [CNT_W-1:0]   STEPS_ADV  = CNT_W'(PROD_W);

    typedef struct packed {
        logic load;        // latch request, form product
        logic div1_start;  // start advance division
        logic add;         // deadline += quotient
        logic clamp_hi;    // clamp to now + one second
        logic clamp_lo;    // clamp to now - two seconds
        logic eval;        // latch "deadline after now"
        logic tick_load;   // latch tick reciprocal product
        logic out_load;    // load result register
    } wrld_cmd_t;

    typedef struct packed {
        logic div_done;
        logic pos;         // deadline strictly after now
    } wrld_stat_t;

endpackage

### design/wrld_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// Uses wrld_pkg widths. Dividend is MSB-aligned; steps sets the bit count.
module wrld_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [wrld_pkg::TIME_W-1:0] dividend,
    input  logic [wrld_pkg::RATE_W-1:0] divisor,
    input  logic [wrld_pkg::CNT_W-1:0]  steps,
    output logic                        done,
    output logic [wrld_pkg::TIME_W-1:0] quotient
);
    import wrld_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [RATE_W-1:0]   rem_reg, rem_next;
    logic [TIME_W-1:0]   quo_reg, quo_next;
    logic [RATE_W-1:0]   div_reg, div_next;
    logic [RATE_W:0]     trial;
    logic                ge;

    assign trial = {rem_reg, quo_reg[TIME_W-1]};
    assign ge    = trial >= {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = steps;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? RATE_W'(trial - {1'b0, div_reg}) : trial[RATE_W-1:0];
            quo_next = {quo_reg[TIME_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a finished run");
    a_cnt_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with empty count");

endmodule

### design/wrld_datapath.sv
// Datapath: rate register, deadline, product, clamps and result register.
// Depends on wrld_pkg and wrld_divider.
module wrld_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  wrld_pkg::wrld_cmd_t          cmd,
    output wrld_pkg::wrld_stat_t         stat,
    input  logic                         cfg_we,
    input  logic [wrld_pkg::RATE_W-1:0]  cfg_data,
    input  logic [wrld_pkg::TIME_W-1:0]  in_time,
    input  logic [wrld_pkg::WORK_W-1:0]  in_work,
    output logic [wrld_pkg::DELAY_W-1:0] delay
);
    import wrld_pkg::*;

    logic [RATE_W-1:0]  rate_reg;
    logic [RATE_W-1:0]  rate_eff;
    logic [TIME_W-1:0]  deadline_reg;
    logic [TIME_W-1:0]  now_reg, ahead_reg, behind_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [TPROD_W-1:0] tick_prod_reg;
    logic [TIME_W-1:0]  tick_q;
    logic               pos_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [TIME_W-1:0]  ahead_diff, behind_diff, now_diff, diff;
    logic               div_start, div_done;
    logic [TIME_W-1:0]  div_dividend, quotient;
    logic [RATE_W-1:0]  div_divisor;
    logic [CNT_W-1:0]   div_steps;

    assign rate_eff = (rate_reg == '0) ? RATE_W'(1) : rate_reg;

    // signed-difference compares, wrap-safe
    assign ahead_diff  = ahead_reg - deadline_reg;
    assign behind_diff = deadline_reg - behind_reg;
    assign now_diff    = now_reg - deadline_reg;
    assign diff        = deadline_reg - now_reg;

    assign div_start    = cmd.div1_start;
    assign div_dividend = {prod_reg, {(TIME_W-PROD_W){1'b0}}};
    assign div_divisor  = rate_eff;
    assign div_steps    = STEPS_ADV;

    assign tick_q = TIME_W'(tick_prod_reg >> TICK_SHIFT);

    wrld_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg     <= RATE_W'(1);
            deadline_reg <= '0;
        end else begin
            if (cfg_we)
                rate_reg <= cfg_data;
            if (cmd.add)
                deadline_reg <= deadline_reg + quotient;
            else if (cmd.clamp_hi && ahead_diff[TIME_W-1])
                deadline_reg <= ahead_reg;
            else if (cmd.clamp_lo && behind_diff[TIME_W-1])
                deadline_reg <= behind_reg;
        end
        if (cmd.load) begin
            now_reg    <= in_time;
            ahead_reg  <= in_time + UNITS_T;
            behind_reg <= in_time - UNITS2_T;
            prod_reg   <= PROD_W'(in_work) * PROD_W'(UNITS_PER_SECOND);
        end
        if (cmd.eval)
            pos_reg <= now_diff[TIME_W-1];
        // the clamped deadline is at most one second ahead, so diff fits UNITS_W bits
        if (cmd.tick_load)
            tick_prod_reg <= TPROD_W'(diff[UNITS_W-1:0]) * TPROD_W'(TICK_RECIP);
        if (cmd.out_load) begin
            if (!pos_reg)
                delay_reg <= '0;
            else if (tick_q > DELAY_MAX)
                delay_reg <= DELAY_MAX[DELAY_W-1:0];
            else
                delay_reg <= tick_q[DELAY_W-1:0];
        end
    end

    assign stat.div_done = div_done;
    assign stat.pos      = now_diff[TIME_W-1];
    assign delay         = delay_reg;

endmodule

### design/wrld_ctrl.sv
// Controller state machine: sequences one request through the datapath.
// Depends on wrld_pkg. Owns both handshakes' control bits.
module wrld_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  wrld_pkg::wrld_stat_t stat,
    output wrld_pkg::wrld_cmd_t  cmd
);
    import wrld_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MSTART = 4'd1;
    localparam logic [3:0] S_MWAIT  = 4'd2;
    localparam logic [3:0] S_ADD    = 4'd3;
    localparam logic [3:0] S_CLHI   = 4'd4;
    localparam logic [3:0] S_CLLO   = 4'd5;
    localparam logic [3:0] S_EVAL   = 4'd6;
    localparam logic [3:0] S_EMIT   = 4'd7;

    logic [3:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MSTART;
                end
            end
            S_MSTART: begin
                cmd.div1_start = 1'b1;
                state_next     = S_MWAIT;
            end
            S_MWAIT: begin
                if (stat.div_done)
                    state_next = S_ADD;
            end
            S_ADD: begin
                cmd.add    = 1'b1;
                state_next = S_CLHI;
            end
            S_CLHI: begin
                cmd.clamp_hi = 1'b1;
                state_next   = S_CLLO;
            end
            S_CLLO: begin
                cmd.clamp_lo = 1'b1;
                state_next   = S_EVAL;
            end
            S_EVAL: begin
                // skip the tick product when the deadline is already due
                cmd.eval = 1'b1;
                if (stat.pos)
                    cmd.tick_load = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                // hold until the result register is free
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten before taken");
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> state_reg == S_MWAIT)
        else $error("divider finished outside the wait state");
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> state_reg == S_MSTART)
        else $error("accepted request did not start");

endmodule

### design/work_rate_limiter_delay.sv
// Top level of the work rate limiter with a virtual deadline.
// Depends on wrld_pkg, wrld_ctrl, wrld_datapath (and wrld_divider below it).
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata[95:0]: current_time, work_done
//  m_       out  m_tvalid/m_tready    m_tdata[15:0]: delay_ticks, zero pad
//  cfg_     in   cfg_valid/cfg_ready  cfg_data[31:0]: work_rate
//
// One request at a time, through the same states whether the
// deadline is ahead or already due. The bit-serial divider for the advance
// runs 62 steps; the tick count is one reciprocal multiply.
// Reset (aresetn low, synchronous) sets work_rate to 1 and deadline to 0.
// A result that waits on m_tready holds in its register; a new request is
// taken meanwhile and stalls only at its own result.
module work_rate_limiter_delay (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // [63:0] current_time, [95:64] work_done
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [9:0] delay_ticks, [15:10] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data   // [31:0] work_rate
);
    import wrld_pkg::*;

    wrld_cmd_t          cmd;
    wrld_stat_t         stat;
    logic [DELAY_W-1:0] delay;

    assign cfg_ready = 1'b1;

    wrld_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wrld_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .in_time  (s_tdata[TIME_W-1:0]),
        .in_work  (s_tdata[TIME_W+WORK_W-1:TIME_W]),
        .delay    (delay)
    );

    assign m_tdata = {{(16-DELAY_W){1'b0}}, delay};

endmodule

### bench/work_rate_limiter_delay_tb.sv
// Testbench for work_rate_limiter_delay: streams work reports through the block and
// checks each delay against an in-bench deadline tracker, across several work_rate settings.
// Depends on wrld_pkg and the design under design/.
module work_rate_limiter_delay_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wrld_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int SETTLE_CYCLES = 150;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [WORK_W-1:0] work_done;
        logic [TIME_W-1:0] current_time;
    } work_req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;   // [63:0] current_time, [95:64] work_done
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [9:0] delay_ticks, [15:10] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;  // [31:0] work_rate

    work_rate_limiter_delay dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Tracker state of the block
    logic [RATE_W-1:0]  rate_q = RATE_W'(1);
    logic [TIME_W-1:0]  deadline_q = '0;

    work_req_t              work_reqs[$];
    logic [DELAY_W-1:0]     due_delays[$];
    int unsigned            err_cnt = 0;
    int unsigned            cycle_cnt = 0;
    bit                     idle_en = 1'b1;
    logic [TIME_W-1:0]      clock_now = '0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic bit earlier(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return d[TIME_W-1];
    endfunction

    // Advance the deadline by one work report and return the wait in ticks
    function automatic logic [DELAY_W-1:0] predict_delay(input logic [TIME_W-1:0] now,
                                                         input logic [WORK_W-1:0] done);
        logic [TIME_W-1:0] rate, ahead, behind, ticks;
        rate = (rate_q == '0) ? TIME_W'(1) : TIME_W'(rate_q);
        ahead = now + UNITS_T;
        behind = now - UNITS2_T;
        ticks = '0;
        deadline_q = deadline_q + (TIME_W'(done) * UNITS_T) / rate;
        if (earlier(ahead, deadline_q))
            deadline_q = ahead;
        if (earlier(deadline_q, behind))
            deadline_q = behind;
        if (earlier(now, deadline_q)) begin
            ticks = (deadline_q - now) / TIME_W'(TICK_LEN);
            if (ticks > DELAY_MAX)
                ticks = DELAY_MAX;
        end
        return ticks[DELAY_W-1:0];
    endfunction

    // Request driver
    bit          tx_busy = 1'b0;
    int          tx_gap = 0;
    work_req_t   tx_req = '0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            tx_busy = 1'b0;
            tx_gap = 0;
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                due_delays.push_back(predict_delay(tx_req.current_time, tx_req.work_done));
                tx_busy = 1'b0;
                if (idle_en && $urandom_range(0, 3) == 0)
                    tx_gap = $urandom_range(1, 12);
            end
            if (!tx_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (work_reqs.size() > 0) begin
                    tx_req = work_reqs.pop_front();
                    tx_busy = 1'b1;
                end
            end
            s_tvalid <= tx_busy;
            s_tdata <= tx_req;
        end
    end

    // Result monitor
    int rx_stall = 0;
    bit rx_ready;

    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_stall = 0;
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_delays.size() == 0) begin
                    $error("unexpected result, delay_ticks %0d", m_tdata[DELAY_W-1:0]);
                    err_cnt++;
                end else begin
                    logic [DELAY_W-1:0] want;
                    want = due_delays.pop_front();
                    if (m_tdata[DELAY_W-1:0] !== want) begin
                        $error("delay_ticks: expected %0d, got %0d", want,
                               m_tdata[DELAY_W-1:0]);
                        err_cnt++;
                    end
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                rx_ready = 1'b0;
            end else begin
                rx_ready = 1'b1;
                if (idle_en && $urandom_range(0, 5) == 0)
                    rx_stall = $urandom_range(1, 12);
            end
            m_tready <= rx_ready;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_req(input logic [TIME_W-1:0] now, input logic [WORK_W-1:0] done);
        work_reqs.push_back('{work_done: done, current_time: now});
    endtask

    // Hold until every request has been taken and every result has come back
    task automatic drain();
        do @(negedge aclk);
        while (work_reqs.size() != 0 || s_tvalid || due_delays.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        rate_q = value;
    endtask

    // Paced work reports: time mostly moves forward a little, work sized so the
    // deadline lands near the window; a share of jumps, rewinds and raw values.
    task automatic fill_paced(input int count);
        logic [TIME_W-1:0] step, target, rate_eff;
        logic [127:0]      wide;
        logic [WORK_W-1:0] done;
        rate_eff = (rate_q == '0) ? TIME_W'(1) : TIME_W'(rate_q);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 15))
                0:       step = {$urandom, $urandom};
                1:       step = TIME_W'(0) - TIME_W'($urandom_range(0, 2000000000));
                2, 3:    step = TIME_W'($urandom_range(0, 1000000000)) * 5;
                default: step = TIME_W'($urandom_range(0, 400000000));
            endcase
            clock_now = clock_now + step;
            target = TIME_W'($urandom_range(0, 1500000000));
            wide = (128'(target) * 128'(rate_eff)) / 128'(UNITS_T);
            done = (wide > 128'(32'hFFFF_FFFF)) ? '1 : wide[WORK_W-1:0];
            if ($urandom_range(0, 7) == 0)
                done = $urandom;
            else if ($urandom_range(0, 3) == 0)
                done = done + WORK_W'($urandom_range(0, 3));
            push_req(clock_now, done);
        end
    endtask

    task automatic run_phase(input logic [RATE_W-1:0] rate, input logic [TIME_W-1:0] start,
                             input int count, input bit idling);
        write_rate(rate);
        idle_en = idling;
        clock_now = start;
        fill_paced(count / 2);
        // pause the sender until the block is empty
        drain();
        fill_paced(count - count / 2);
        drain();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, reset rate of one: due, far ahead, far behind, wraps
        @(negedge aclk);
        push_req(64'd0, 32'd0);
        push_req(64'd0, 32'd1);
        push_req(64'd0, 32'hFFFF_FFFF);
        push_req(64'd500000000, 32'd0);
        push_req(64'd10000000000, 32'd0);
        push_req(64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        push_req(64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
        push_req(64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
        push_req(64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
        push_req(64'd200000000, 32'd0);
        push_req(64'h7FFF_FFFF_FFFF_FFFF, 32'd0);
        push_req(64'h8000_0000_0000_0000, 32'd1);
        push_req(64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
        push_req(64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
        for (int i = 0; i < 4; i++)
            push_req({$urandom, $urandom}, $urandom);
        drain();

        // Zero rate acts as one; full-scale rate gives one second per full work count
        write_rate(32'd0);
        @(negedge aclk);
        push_req(64'd1000, 32'd1);
        push_req(64'd1000, 32'd0);
        push_req(64'd300001000, 32'd0);
        drain();
        write_rate(32'hFFFF_FFFF);
        @(negedge aclk);
        push_req(64'd40000000000, 32'hFFFF_FFFF);
        push_req(64'd40000000000, 32'd0);
        push_req(64'd40000000000, 32'd1);
        drain();

        run_phase(32'd1000, 64'd0, 110, 1'b1);
        run_phase(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF - 64'd3000000000, 110, 1'b1);
        run_phase(32'd0, {$urandom, $urandom}, 100, 1'b0);
        run_phase($urandom, {$urandom, $urandom}, 100, 1'b1);
        run_phase(32'd1, 64'h7FFF_FFFF_0000_0000, 100, 1'b1);
        run_phase(RATE_W'($urandom_range(1, 5000)), {$urandom, $urandom}, 100, 1'b0);

        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
